// ===== design/rpn_stack_evaluator_assert.svh =====
// Assertion macros used by the RPN stack evaluator sequencer, rpn_seq.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define RPN_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rpn_stack_evaluator: assertion failed");
`define RPN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpn_stack_evaluator: assertion failed");
`else
`define RPN_ASSERT(label, prop)
`define RPN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/rpn_pkg.sv =====
// Shared types, constants and helper functions for the RPN stack evaluator.
// No dependencies; rpn_alu, rpn_seq and rpn_stack_evaluator import this package.
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int WORD_W      = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int FUNC_W      = 3;
    localparam int LIMIT_W     = 5;
    localparam int OPND_W      = 32;
    localparam int OUT_DEPTH_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH = 3'd0,
        FN_ADD  = 3'd1,
        FN_SUB  = 3'd2,
        FN_MUL  = 3'd3,
        FN_END  = 3'd4
    } rpn_func_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_OVERFLOW  = 2'd1,
        STS_UNDERFLOW = 2'd2,
        STS_BADEND    = 2'd3
    } rpn_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC
    } rpn_state_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } rpn_alu_op_t;

    typedef struct packed {
        logic        en;
        rpn_alu_op_t op;
    } rpn_alu_ctrl_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } rpn_ram_req_t;

    // Limit of zero behaves as one; anything above the physical depth is clamped.
    function automatic logic [DEPTH_W-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
        logic [DEPTH_W-1:0] r;
        if (lim == '0)
            r = DEPTH_W'(1);
        else if (int'(lim) > STACK_DEPTH)
            r = DEPTH_W'(STACK_DEPTH);
        else
            r = DEPTH_W'(lim);
        return r;
    endfunction

endpackage

// ===== design/rpn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rpn_alu.sv =====
// Shared arithmetic unit: add, subtract or multiply, result registered.
// Depends on rpn_pkg.
module rpn_alu
    import rpn_pkg::*;
(
    input  logic              clk,
    input  rpn_alu_ctrl_t     ctrl,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic [WORD_W-1:0] result
);

    logic [WORD_W-1:0] result_reg;
    logic [WORD_W-1:0] result_next;

    always_comb
    begin
        case (ctrl.op)
            ALU_ADD: result_next = a + b;
            ALU_SUB: result_next = a - b;
            ALU_MUL: result_next = WORD_W'(a * b);
            default: result_next = a;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ===== design/rpn_seq.sv =====
// Sequencer: stack pointer, top-of-stack register, limit register and result registers.
// Depends on rpn_pkg and rpn_stack_evaluator_assert.svh.
`include "rpn_stack_evaluator_assert.svh"

module rpn_seq
    import rpn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  func,
    input  logic [WORD_W-1:0]  operand_word,
    input  logic               limit_we,
    input  logic [LIMIT_W-1:0] limit_wdata,
    output rpn_ram_req_t       ram_req,
    input  logic [WORD_W-1:0]  ram_rdata,
    output rpn_alu_ctrl_t      alu_ctrl,
    output logic [WORD_W-1:0]  alu_a,
    output logic [WORD_W-1:0]  alu_b,
    input  logic [WORD_W-1:0]  alu_result,
    output logic               done,
    output logic [1:0]         status,
    output logic [WORD_W-1:0]  shown,
    output logic [DEPTH_W-1:0] depth
);

    rpn_state_t         state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               done_reg, done_next;
    rpn_status_t        status_reg, status_next;
    logic [WORD_W-1:0]  shown_reg, shown_next;
    logic [WORD_W-1:0]  top_reg, top_next;
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [WORD_W-1:0]  operand_reg, operand_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            limit_reg <= LIMIT_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            done_reg  <= done_next;
            if (limit_we)
                limit_reg <= limit_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        shown_reg   <= shown_next;
        top_reg     <= top_next;
        func_reg    <= func_next;
        operand_reg <= operand_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        shown_next   = shown_reg;
        top_next     = top_reg;
        func_next    = func_reg;
        operand_next = operand_reg;

        // The RAM holds every entry below the top; the top lives in top_reg.
        ram_req.we    = 1'b0;
        ram_req.waddr = ADDR_W'(depth_reg - DEPTH_W'(1));
        ram_req.wdata = top_reg;
        ram_req.raddr = ADDR_W'(depth_reg - DEPTH_W'(2));

        alu_ctrl.en = 1'b0;
        alu_ctrl.op = ALU_ADD;
        alu_a       = ram_rdata;
        alu_b       = top_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next    = func;
                    operand_next = operand_word;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = STS_OK;
                case (func_reg)
                    FN_PUSH:
                    begin
                        if (depth_reg >= eff_limit(limit_reg))
                        begin
                            status_next = STS_OVERFLOW;
                            shown_next  = (depth_reg == '0) ? '0 : top_reg;
                        end
                        else
                        begin
                            ram_req.we = (depth_reg != '0);
                            top_next   = operand_reg;
                            shown_next = operand_reg;
                            depth_next = depth_reg + DEPTH_W'(1);
                        end
                    end
                    FN_ADD, FN_SUB, FN_MUL:
                    begin
                        if (depth_reg < DEPTH_W'(2))
                        begin
                            status_next = STS_UNDERFLOW;
                            depth_next  = '0;
                            shown_next  = '0;
                        end
                        else
                        begin
                            alu_ctrl.en = 1'b1;
                            case (func_reg)
                                FN_ADD:  alu_ctrl.op = ALU_ADD;
                                FN_SUB:  alu_ctrl.op = ALU_SUB;
                                default: alu_ctrl.op = ALU_MUL;
                            endcase
                            done_next  = 1'b0;
                            state_next = S_EXEC;
                        end
                    end
                    FN_END:
                    begin
                        if (depth_reg == DEPTH_W'(1))
                            shown_next = top_reg;
                        else
                        begin
                            status_next = STS_BADEND;
                            shown_next  = '0;
                        end
                        depth_next = '0;
                    end
                    default:
                    begin
                        shown_next = (depth_reg == '0) ? '0 : top_reg;
                    end
                endcase
            end
            S_EXEC:
            begin
                top_next   = alu_result;
                shown_next = alu_result;
                depth_next = depth_reg - DEPTH_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign shown  = shown_reg;
    assign depth  = depth_reg;

    `RPN_ASSERT(a_depth_bound, depth_reg <= DEPTH_W'(STACK_DEPTH))
    `RPN_ASSERT(a_done_source,
        !done_reg || $past(state_reg) == S_DECODE || $past(state_reg) == S_EXEC)
    `RPN_ASSERT_NEXT(a_accept_decode, start && state_reg == S_IDLE, state_reg == S_DECODE)
    `RPN_ASSERT(a_overflow_keeps_depth,
        !(done_reg && status_reg == STS_OVERFLOW) || $stable(depth_reg))
    `RPN_ASSERT(a_underflow_clears,
        !(done_reg && status_reg == STS_UNDERFLOW) || (depth_reg == '0 && shown_reg == '0))

endmodule

// ===== design/rpn_stack_evaluator.sv =====
// Reverse Polish integer evaluator on a bounded stack: ports and unit wiring.
// Depends on rpn_pkg, rpn_ram, rpn_alu and rpn_seq.
//
// Usage: raise start with func and operand while busy is low; the token is
// taken at that clock edge. func selects push, add, subtract, multiply or end
// of expression. Exactly one result follows per token: done is high for one
// cycle with status, top_value and depth valid in that same cycle. The
// receiver cannot stall, so the result must be captured while done is high.
// For push, end, unused codes and any operation with fewer than two entries,
// done is registered from the decode state. Add, subtract and multiply on two
// or more entries go from the decode state to the execute state, and done is
// registered from there. The entry below the top is read from the stack RAM,
// and the shared ALU result is registered before write-back. busy is high from
// acceptance until the result cycle, and a new token may already be taken in
// that cycle. The user must write the stack_limit register through
// stack_limit_we and stack_limit only while idle; the block does not enforce it.
// Reset empties the stack and sets the limit to 16. Stack RAM is not cleared.
module rpn_stack_evaluator
    import rpn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [FUNC_W-1:0]          func,
    input  logic signed [OPND_W-1:0]   operand,
    input  logic                       stack_limit_we,
    input  logic [LIMIT_W-1:0]         stack_limit,
    output logic                       done,
    output logic [1:0]                 status,
    output logic signed [OPND_W-1:0]   top_value,
    output logic [OUT_DEPTH_W-1:0]     depth
);

    rpn_ram_req_t       ram_req;
    logic [WORD_W-1:0]  ram_rdata;
    rpn_alu_ctrl_t      alu_ctrl;
    logic [WORD_W-1:0]  alu_a;
    logic [WORD_W-1:0]  alu_b;
    logic [WORD_W-1:0]  alu_result;
    logic [WORD_W-1:0]  operand_word;
    logic [WORD_W-1:0]  shown;
    logic [DEPTH_W-1:0] depth_int;

    assign operand_word = WORD_W'(operand);

    rpn_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .operand_word (operand_word),
        .limit_we     (stack_limit_we),
        .limit_wdata  (stack_limit),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata),
        .alu_ctrl     (alu_ctrl),
        .alu_a        (alu_a),
        .alu_b        (alu_b),
        .alu_result   (alu_result),
        .done         (done),
        .status       (status),
        .shown        (shown),
        .depth        (depth_int)
    );

    rpn_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    rpn_alu u_alu (
        .clk    (clk),
        .ctrl   (alu_ctrl),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result)
    );

    // The 32-bit word is cast to the 32-bit port and passes through unchanged.
    assign top_value = OPND_W'(shown);
    assign depth     = OUT_DEPTH_W'(depth_int);

endmodule
